### hdl/scms_pkg.sv
package scms_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned LOW_W   = 10;
   localparam int unsigned COL_W   = 10;
   localparam int unsigned FEAT_W  = 4;
   localparam int unsigned MAXROWS = 4;
   localparam logic [WORD_W-1:0] ALL_ONES = '1;
   localparam logic [WORD_W-1:0] LOW_MASK = WORD_W'((1 << LOW_W) - 1);

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_QUERY  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                        kind;
      logic [MAXROWS-1:0][COL_W-1:0]   cols;
   } cmd_type;

   typedef struct packed {
      logic [WORD_W-1:0] estimate;
      logic [FEAT_W-1:0] feature_increment;
      logic              applied;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WRITE
   } state_type;

endpackage

### hdl/scms_front.sv
module scms_front import scms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  cmd_type       req_cmd,
   output logic          q_valid,
   input  logic          q_take,
   output cmd_type       q_cmd
);

   cmd_type    buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_take;
   assign q_cmd     = buf_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
      end
      if (push) buf_ff[wp_ff] <= req_cmd;
   end

endmodule

### hdl/scms_back.sv
module scms_back import scms_pkg::*; #(
   parameter int unsigned ROWS    = 4,
   parameter int unsigned COLUMNS = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   output logic    q_take,
   input  cmd_type q_cmd,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned CA_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int unsigned DIV_S = COL_W + CA_W;
   localparam int unsigned PRD_W = 2 * COL_W + 2;
   localparam logic [PRD_W-1:0] DIV_M =
      PRD_W'(((64'd1 << DIV_S) + 64'(COLUMNS) - 64'd1) / 64'(COLUMNS));

   logic [WORD_W-1:0] mem_w [ROWS][COLUMNS];
   logic              mem_f [ROWS][COLUMNS];

   state_type         st_ff, st_in;
   logic [CA_W-1:0]   clr_ff;
   cmd_type           cmd_ff;
   logic [CA_W-1:0]   addr_ff [ROWS];
   logic [WORD_W-1:0] rd_w_ff [ROWS];
   logic              rd_f_ff [ROWS];
   logic              ov_ff;
   rsp_type           out_ff;

   logic [WORD_W-1:0] inc [ROWS];
   logic              nf [ROWS];
   logic [WORD_W-1:0] best, qbest;
   logic [FEAT_W-1:0] feat;
   logic              drop;

   // column modulo COLUMNS by reciprocal multiply; exact for 10-bit columns
   function automatic logic [CA_W-1:0] col_wrap(logic [COL_W-1:0] col);
      logic [PRD_W-1:0] prod;
      logic [COL_W-1:0] quo, rem;
      prod = PRD_W'(col) * DIV_M;
      quo  = COL_W'(prod >> DIV_S);
      rem  = col - COL_W'(quo * COL_W'(COLUMNS));
      return CA_W'(rem);
   endfunction

   always_comb begin
      best  = ALL_ONES;
      qbest = ALL_ONES;
      feat  = '0;
      drop  = 1'b0;
      for (int r = 0; r < ROWS; r++) begin
         inc[r] = (rd_f_ff[r] ? rd_w_ff[r] : (rd_w_ff[r] & LOW_MASK)) + WORD_W'(1);
         nf[r]  = rd_f_ff[r] || (inc[r] > LOW_MASK);
         if (inc[r] < best) best = inc[r];
         if ((rd_f_ff[r] ? rd_w_ff[r] : (rd_w_ff[r] & LOW_MASK)) < qbest)
            qbest = rd_f_ff[r] ? rd_w_ff[r] : (rd_w_ff[r] & LOW_MASK);
         feat = feat + (rd_f_ff[r] ? FEAT_W'(1) : FEAT_W'(2));
         if (rd_w_ff[r] == ALL_ONES) drop = 1'b1;
      end
   end

   // one result slot; refilled only once taken
   assign q_take = (st_ff == ST_IDLE) && !ov_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_CLEAR: if (32'(clr_ff) == COLUMNS - 1) st_in = ST_IDLE;
         ST_IDLE:  if (q_valid && !ov_ff) st_in = ST_READ;
         ST_READ:  st_in = ST_WRITE;
         ST_WRITE: st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_CLEAR;
         clr_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_CLEAR) clr_ff <= clr_ff + CA_W'(1);
         if (st_ff == ST_WRITE) ov_ff <= 1'b1;
         else if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
      end
      if (q_take && q_valid) begin
         cmd_ff <= q_cmd;
         for (int r = 0; r < ROWS; r++) addr_ff[r] <= col_wrap(q_cmd.cols[r]);
      end
      if (st_ff == ST_WRITE) begin
         if (cmd_ff.kind == KIND_QUERY) begin
            out_ff.estimate          <= qbest;
            out_ff.feature_increment <= feat;
            out_ff.applied           <= 1'b1;
         end else begin
            out_ff.estimate          <= drop ? '0 : best;
            out_ff.feature_increment <= '0;
            out_ff.applied           <= !drop;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < ROWS; r++) begin
         if (st_ff == ST_CLEAR) begin
            mem_w[r][clr_ff] <= '0;
            mem_f[r][clr_ff] <= 1'b0;
         end else if (st_ff == ST_WRITE && cmd_ff.kind == KIND_INSERT && !drop) begin
            mem_w[r][addr_ff[r]] <= nf[r] ? inc[r] :
                                    inc[r] + {best[WORD_W-LOW_W-1:0], {LOW_W{1'b0}}};
            mem_f[r][addr_ff[r]] <= nf[r];
         end
         rd_w_ff[r] <= mem_w[r][addr_ff[r]];
         rd_f_ff[r] <= mem_f[r][addr_ff[r]];
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

endmodule

### hdl/split_counter_count_min_sketch.sv
// Count-min sketch with split counters; column hashing is done upstream.
// req channel: kind (insert/query) and one column index per row, taken on
// req_valid && !req_stall. rsp channel: one response per request, in order,
// taken on rsp_valid && !rsp_stall.
// A two-entry request queue feeds the row engine. Each request passes
// through the engine in order: load, read of the row memories, update and
// write back, then a wait for the single response slot to empty, so the
// engine takes no new request before the last response has been taken.
// Throughput is set by the single read-modify-write port per row memory
// and the one-deep response slot.
// After reset the engine clears the counter memories, one column per cycle;
// requests queue meanwhile and req_stall rises once the queue is full.
// While rsp_stall is high the response is held and the engine waits; the
// queue keeps taking requests until full.
module split_counter_count_min_sketch import scms_pkg::*; #(
   parameter int unsigned ROWS    = 4,
   parameter int unsigned COLUMNS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [COL_W-1:0]    req_row0_column,
   input  logic [COL_W-1:0]    req_row1_column,
   input  logic [COL_W-1:0]    req_row2_column,
   input  logic [COL_W-1:0]    req_row3_column,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [WORD_W-1:0]   rsp_estimate,
   output logic [FEAT_W-1:0]   rsp_feature_increment,
   output logic                rsp_applied
);

   cmd_type req_cmd, q_cmd;
   logic    q_valid, q_take;
   rsp_type rsp_data;

   assign req_cmd.kind = kind_type'(req_kind);
   assign req_cmd.cols = {req_row3_column, req_row2_column, req_row1_column, req_row0_column};

   scms_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd,
      .q_valid, .q_take, .q_cmd
   );

   scms_back #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_cmd,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   assign rsp_estimate          = rsp_data.estimate;
   assign rsp_feature_increment = rsp_data.feature_increment;
   assign rsp_applied           = rsp_data.applied;

endmodule
